// ----- design/lrdp_pkg.sv -----
// Package: sizes, beat payload types and chain control type for the LRU demand pager.
package lrdp_pkg;

  localparam int NUM_FRAMES        = 8;
  localparam int NUM_PROCESSES     = 8;
  localparam int PAGES_PER_PROCESS = 16;
  localparam int NUM_SLOTS         = NUM_PROCESSES * PAGES_PER_PROCESS;

  localparam int PID_W   = 3;
  localparam int VP_W    = 4;
  localparam int IDX_W   = PID_W + VP_W;
  localparam int FRAME_W = 3;
  localparam int SLOT_W  = 7;
  localparam int CNT_W   = FRAME_W + 1;
  localparam int ALLOC_W = SLOT_W + 1;

  typedef struct packed {
    logic [PID_W-1:0] process_id;
    logic [VP_W-1:0]  virtual_page;
    logic             is_write;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic               evicted_valid;
    logic [PID_W-1:0]   evicted_process;
    logic [VP_W-1:0]    evicted_page;
    logic               writeback_valid;
    logic [SLOT_W-1:0]  writeback_slot;
    logic               fill_valid;
    logic [SLOT_W-1:0]  fill_slot;
  } out_t;

  // page table entry; number is a frame while present, a swap slot while mapped
  typedef struct packed {
    logic              present;
    logic              dirty;
    logic              mapped;
    logic [SLOT_W-1:0] number;
  } pte_t;

  // command broadcast to every recency cell
  typedef struct packed {
    logic             touch;   // remove target (or head on evict), put target at tail
    logic             append;  // write target into the tail cell
    logic [IDX_W-1:0] target;
  } cell_ctl_t;

endpackage

// ----- design/lrdp_cell.sv -----
// One recency cell: holds one resident page index, shifts toward the LRU end.
module lrdp_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lrdp_pkg::cell_ctl_t      ctl,
  input  logic                     tail,
  input  logic                     seen_in,
  input  logic [lrdp_pkg::IDX_W-1:0] right_idx,
  output logic                     seen_out,
  output logic [lrdp_pkg::IDX_W-1:0] idx
);
  import lrdp_pkg::*;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             vld_r, vld_nxt;

  // seen passes down the row: set from the matching cell onward
  assign seen_out = seen_in | (vld_r && (idx_r == ctl.target));
  assign idx      = idx_r;

  always_comb begin
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    if (ctl.append && tail) begin
      idx_nxt = ctl.target;
      vld_nxt = 1'b1;
    end else if (ctl.touch) begin
      if (tail) begin
        idx_nxt = ctl.target;
      end else if (seen_out) begin
        idx_nxt = right_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    idx_r <= idx_nxt;
  end

endmodule

// ----- design/lru_demand_pager_with_swap.sv -----
// Top level: LRU demand pager with swap, page table memory and recency cell row.
//
// One access per start beat; busy stays high until the result beat is built.
// A hit passes S_LOOK; a miss also passes S_FILL, with S_VICT before it when it
// evicts. The result strobe out_valid rises at the same edge at which busy falls
// and lasts one cycle, and the receiver cannot stall it. These paths are set by
// the single read port of the page table: the accessed entry and the victim
// entry are read one after the other, and each write back has its own state.
// The LRU order lives in a row of eight cells that shift toward the head.
// Swap slots are never released, so the lowest unused slot is a count.
module lru_demand_pager_with_swap (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  lrdp_pkg::in_t  in_data,
  output logic           out_valid,
  output lrdp_pkg::out_t out_data
);
  import lrdp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_VICT = 2'd2;
  localparam logic [1:0] S_FILL = 2'd3;

  logic [1:0]         state_r, state_nxt;
  in_t                item_r;
  pte_t               ent_r, ent_nxt;
  out_t               res_r, res_nxt;
  out_t               out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [NUM_FRAMES-1:0] fbusy_r, fbusy_nxt;
  logic [NUM_FRAMES-1:0] org_has_r;
  logic [SLOT_W-1:0]  org_slot_r [NUM_FRAMES];
  logic               org_we;
  logic               org_has_wd;
  logic [SLOT_W-1:0]  org_slot_wd;
  logic [ALLOC_W-1:0] alloc_r, alloc_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic               evicted_r, evicted_nxt;

  // page table: registered read, one write per cycle
  pte_t               pt_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] pt_vld_r;
  pte_t               pt_rd_r;
  logic               pt_rd_vld_r;
  logic [IDX_W-1:0]   rd_addr;
  logic               pt_we;
  logic [IDX_W-1:0]   pt_wa;
  pte_t               pt_wd;
  pte_t               rd_ent;

  // recency row
  cell_ctl_t          ctl;
  logic [CNT_W-1:0]   tail_pos;
  logic [NUM_FRAMES:0] seen;
  logic [IDX_W-1:0]   cell_idx [NUM_FRAMES+1];

  logic [IDX_W-1:0]   item_idx;
  logic [FRAME_W-1:0] free_f;
  logic [FRAME_W-1:0] pf;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign item_idx  = {item_r.process_id, item_r.virtual_page};
  assign rd_addr   = (state_r == S_IDLE) ? {in_data.process_id, in_data.virtual_page}
                                         : cell_idx[0];
  assign rd_ent    = pt_rd_vld_r ? pt_rd_r : '0;
  assign pf        = rd_ent.number[FRAME_W-1:0];

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_wa] <= pt_wd;
    end
    pt_rd_r <= pt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_vld_r    <= '0;
      pt_rd_vld_r <= 1'b0;
    end else begin
      if (pt_we) begin
        pt_vld_r[pt_wa] <= 1'b1;
      end
      pt_rd_vld_r <= pt_vld_r[rd_addr];
    end
  end

  // lowest free frame
  always_comb begin
    free_f = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (!fbusy_r[i]) begin
        free_f = FRAME_W'(i);
      end
    end
  end

  // cell row: head is least recent
  assign cell_idx[NUM_FRAMES] = '0;
  assign tail_pos = ctl.touch ? (count_r - CNT_W'(1)) : count_r;

  generate
    for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
      lrdp_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .tail      (tail_pos == CNT_W'(g)),
        .seen_in   (seen[g]),
        .right_idx (cell_idx[g+1]),
        .seen_out  (seen[g+1]),
        .idx       (cell_idx[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    ent_nxt       = ent_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    count_nxt     = count_r;
    fbusy_nxt     = fbusy_r;
    alloc_nxt     = alloc_r;
    frame_nxt     = frame_r;
    evicted_nxt   = evicted_r;
    org_we        = 1'b0;
    org_has_wd    = 1'b0;
    org_slot_wd   = '0;
    pt_we         = 1'b0;
    pt_wa         = item_idx;
    pt_wd         = '0;
    ctl           = '0;
    ctl.target    = item_idx;
    seen[0]       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        ent_nxt     = rd_ent;
        res_nxt     = '0;
        evicted_nxt = 1'b0;
        if (rd_ent.present) begin
          // hit: move to most-recent end, maybe mark dirty
          pt_we        = 1'b1;
          pt_wd        = rd_ent;
          pt_wd.dirty  = rd_ent.dirty | item_r.is_write;
          ctl.touch    = 1'b1;
          out_nxt      = '0;
          out_nxt.hit  = 1'b1;
          out_nxt.frame = rd_ent.number[FRAME_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end else if (count_r == CNT_W'(NUM_FRAMES)) begin
          state_nxt = S_VICT;   // head entry is being read this edge
        end else begin
          frame_nxt = free_f;
          state_nxt = S_FILL;
        end
      end
      S_VICT: begin
        // victim is the head cell; its frame is the only one that frees up
        pt_we       = 1'b1;
        pt_wa       = cell_idx[0];
        pt_wd       = '0;
        res_nxt.evicted_valid   = 1'b1;
        res_nxt.evicted_process = cell_idx[0][IDX_W-1:VP_W];
        res_nxt.evicted_page    = cell_idx[0][VP_W-1:0];
        if (org_has_r[pf]) begin
          pt_wd.mapped = 1'b1;
          pt_wd.number = org_slot_r[pf];
          if (rd_ent.dirty) begin
            res_nxt.writeback_valid = 1'b1;
            res_nxt.writeback_slot  = org_slot_r[pf];
          end
        end else if (alloc_r != ALLOC_W'(NUM_SLOTS)) begin
          pt_wd.mapped = 1'b1;
          pt_wd.number = alloc_r[SLOT_W-1:0];
          res_nxt.writeback_valid = 1'b1;
          res_nxt.writeback_slot  = alloc_r[SLOT_W-1:0];
          alloc_nxt = alloc_r + ALLOC_W'(1);
        end
        // drop head, new page to tail in one shift
        ctl.touch   = 1'b1;
        seen[0]     = 1'b1;
        frame_nxt   = pf;
        evicted_nxt = 1'b1;
        state_nxt   = S_FILL;
      end
      S_FILL: begin
        pt_we        = 1'b1;
        pt_wd        = '0;
        pt_wd.present = 1'b1;
        pt_wd.dirty  = item_r.is_write;
        pt_wd.number = SLOT_W'(frame_r);
        org_we       = 1'b1;
        org_has_wd   = ent_r.mapped;
        org_slot_wd  = ent_r.mapped ? ent_r.number : '0;
        if (!evicted_r) begin
          ctl.append = 1'b1;
          count_nxt  = count_r + CNT_W'(1);
          fbusy_nxt[frame_r] = 1'b1;
        end
        out_nxt       = res_r;
        out_nxt.frame = frame_r;
        if (ent_r.mapped) begin
          out_nxt.fill_valid = 1'b1;
          out_nxt.fill_slot  = ent_r.number;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      fbusy_r     <= '0;
      org_has_r   <= '0;
      alloc_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      fbusy_r     <= fbusy_nxt;
      alloc_r     <= alloc_nxt;
      if (org_we) begin
        org_has_r[frame_r] <= org_has_wd;
      end
    end
    if (org_we) begin
      org_slot_r[frame_r] <= org_slot_wd;
    end
    if (start && !busy) begin
      item_r <= in_data;
    end
    ent_r     <= ent_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
    frame_r   <= frame_nxt;
    evicted_r <= evicted_nxt;
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(NUM_FRAMES))
    else $error("resident count above frame count");

  a_busy_frames: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(fbusy_r) == int'(count_r))
    else $error("busy frames disagree with resident count");

  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) == S_LOOK || $past(state_r) == S_FILL)
    else $error("result beat without finished access");

  a_vict_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_VICT |-> count_r == CNT_W'(NUM_FRAMES))
    else $error("eviction with free frame");

endmodule
